>>> sv/hqe_pkg.sv
// Shared types, character constants and helpers for the header Q-word encoder.
package hqe_pkg;

	localparam int LEN_W = 4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_UPPER_Q = 8'h51;
	localparam logic [7:0] CH_CTRL_TOP = 8'h1F;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	localparam logic REG_CHARSET_BYTES = 1'b0;
	localparam logic REG_CHARSET_LENGTH = 1'b1;

	localparam logic [LEN_W-1:0] CHARSET_LENGTH_RESET = 4'd5;

	// What one input byte turns into
	typedef struct packed {
		logic [7:0] data;
		logic       header;
		logic       escape;
		logic       trailer;
	} hqe_plan_t;

	typedef enum logic [3:0] {
		STEP_HDR_EQ,
		STEP_HDR_OPEN,
		STEP_CHARSET,
		STEP_HDR_SEP,
		STEP_HDR_Q,
		STEP_HDR_CLOSE,
		STEP_BODY,
		STEP_HEX_HI,
		STEP_HEX_LO,
		STEP_TRL_Q,
		STEP_TRL_EQ
	} hqe_step_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			hex_char = CH_DIGIT0 + {4'd0, nib};
		end else begin
			hex_char = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
	endfunction

endpackage

>>> sv/hqe_classify.sv
// Byte classification and phase tracking for the header Q-word encoder.
module hqe_classify import hqe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output hqe_plan_t  plan
);

	logic encoding_q;
	logic all_blank_q;
	logic safe;
	logic go;
	logic enc_now;

	always_comb begin
		safe = (in_byte > CH_CTRL_TOP) && (in_byte < CH_DEL) && (in_byte != CH_EQUALS)
			&& (in_byte != CH_QMARK) && (in_byte != CH_UNDERSCORE);
		// a string of spaces only gets its final space encoded
		go = !encoding_q && (!safe || (all_blank_q && in_byte == CH_SPACE && in_last));
		enc_now = encoding_q || go;
		plan.data = in_byte;
		plan.header = go;
		plan.escape = enc_now && (!safe || in_byte == CH_SPACE);
		plan.trailer = enc_now && in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q <= 1'b0;
			all_blank_q <= 1'b1;
		end else if (accept) begin
			if (in_last) begin
				encoding_q <= 1'b0;
				all_blank_q <= 1'b1;
			end else begin
				encoding_q <= enc_now;
				if (!encoding_q && safe && in_byte != CH_SPACE) begin
					all_blank_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> sv/hqe_emit.sv
// Character sequencer and output register for the header Q-word encoder.
module hqe_emit import hqe_pkg::*; #(
	parameter int CHARSET_MAX = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  hqe_plan_t                      plan,
	input  logic [CHARSET_MAX-1:0][7:0]    cs_bytes,
	input  logic [LEN_W-1:0]               cs_len,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_char,
	output logic                           run_end
);

	localparam int IDX_W = (CHARSET_MAX > 1) ? $clog2(CHARSET_MAX) : 1;

	hqe_plan_t        item_q;
	logic             item_valid_q;
	hqe_step_t        step_q;
	hqe_step_t        step_d;
	logic [IDX_W-1:0] cs_idx_q;
	logic [IDX_W-1:0] cs_idx_d;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             run_end_q;
	logic [7:0]       ch;
	logic             final_ch;
	logic             adv;
	logic             load;

	assign adv = item_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_q || (adv && final_ch);
	assign load = in_valid && in_ready;

	always_comb begin
		step_d = step_q;
		cs_idx_d = cs_idx_q;
		ch = item_q.data;
		final_ch = 1'b0;
		case (step_q)
			STEP_HDR_EQ: begin
				ch = CH_EQUALS;
				step_d = STEP_HDR_OPEN;
			end
			STEP_HDR_OPEN: begin
				ch = CH_QMARK;
				step_d = (cs_len == '0) ? STEP_HDR_SEP : STEP_CHARSET;
			end
			STEP_CHARSET: begin
				ch = cs_bytes[cs_idx_q];
				cs_idx_d = cs_idx_q + 1'b1;
				if (LEN_W'(cs_idx_q) + 1'b1 == cs_len) begin
					step_d = STEP_HDR_SEP;
				end
			end
			STEP_HDR_SEP: begin
				ch = CH_QMARK;
				step_d = STEP_HDR_Q;
			end
			STEP_HDR_Q: begin
				ch = CH_UPPER_Q;
				step_d = STEP_HDR_CLOSE;
			end
			STEP_HDR_CLOSE: begin
				ch = CH_QMARK;
				step_d = STEP_BODY;
			end
			STEP_BODY: begin
				if (item_q.escape) begin
					ch = CH_EQUALS;
					step_d = STEP_HEX_HI;
				end else begin
					ch = item_q.data;
					if (item_q.trailer) begin
						step_d = STEP_TRL_Q;
					end else begin
						final_ch = 1'b1;
					end
				end
			end
			STEP_HEX_HI: begin
				ch = hex_char(item_q.data[7:4]);
				step_d = STEP_HEX_LO;
			end
			STEP_HEX_LO: begin
				ch = hex_char(item_q.data[3:0]);
				if (item_q.trailer) begin
					step_d = STEP_TRL_Q;
				end else begin
					final_ch = 1'b1;
				end
			end
			STEP_TRL_Q: begin
				ch = CH_QMARK;
				step_d = STEP_TRL_EQ;
			end
			STEP_TRL_EQ: begin
				ch = CH_EQUALS;
				final_ch = 1'b1;
			end
			default: begin
				final_ch = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			step_q <= STEP_BODY;
			cs_idx_q <= '0;
		end else if (load) begin
			item_valid_q <= 1'b1;
			step_q <= plan.header ? STEP_HDR_EQ : STEP_BODY;
			cs_idx_q <= '0;
		end else if (adv) begin
			// drop the item once its final character is out
			if (final_ch) begin
				item_valid_q <= 1'b0;
			end
			step_q <= step_d;
			cs_idx_q <= cs_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= ch;
			run_end_q <= final_ch;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign run_end = run_end_q;

`ifndef NO_ASSERTIONS
	a_load_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> item_valid_q)
		else $error("accepted byte not held by sequencer");

	a_charset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_q && step_q == STEP_CHARSET |-> LEN_W'(cs_idx_q) < cs_len)
		else $error("charset index beyond configured length");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_end |=> out_valid)
		else $error("run broken before its final character");

	a_trailer_only_when_planned: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_q && (step_q == STEP_TRL_Q || step_q == STEP_TRL_EQ) |-> item_q.trailer)
		else $error("trailer emitted for a byte that needs none");
`endif

endmodule

>>> sv/header_q_word_encoder.sv
// Top level of the header Q-word encoder: configuration registers and wiring.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  input    | in_valid / in_ready  | in_byte, in_last
//  output   | out_valid / out_ready| out_char, run_end
//  config   | cfg_en (write only)  | cfg_index, cfg_data
//
// One output character per cycle while out_ready is high; a byte yields 1 when
// copied, 3 when escaped, plus 5 + charset length for the opening header and 2
// for "?=" - 1 to 18 characters, all from the single character sequencer.
// The next byte is taken in the cycle its predecessor's last character moves
// into the output register; one-character bytes stream at one per cycle unless
// stalled, and a stalled output holds its character and the sequencer. Reset
// clears phase, sequencer and output valid flag; charset length resets to five.
module header_q_word_encoder import hqe_pkg::*; #(
	parameter int CHARSET_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        run_end
);

	logic [CHARSET_MAX-1:0][7:0] cs_bytes_q;
	logic [LEN_W-1:0]            cs_len_q;
	logic [LEN_W-1:0]            cs_len_eff;
	hqe_plan_t                   plan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_bytes_q <= '0;
			cs_len_q <= CHARSET_LENGTH_RESET;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_CHARSET_BYTES: cs_bytes_q <= cfg_data[CHARSET_MAX*8-1:0];
				REG_CHARSET_LENGTH: cs_len_q <= cfg_data[LEN_W-1:0];
				default: cs_len_q <= cs_len_q;
			endcase
		end
	end

	// clamp to the stored charset width
	assign cs_len_eff = (cs_len_q > LEN_W'(CHARSET_MAX)) ? LEN_W'(CHARSET_MAX) : cs_len_q;

	hqe_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_valid && in_ready),
		.in_byte (in_byte),
		.in_last (in_last),
		.plan    (plan)
	);

	hqe_emit #(
		.CHARSET_MAX (CHARSET_MAX)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.plan      (plan),
		.cs_bytes  (cs_bytes_q),
		.cs_len    (cs_len_eff),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.run_end   (run_end)
	);

endmodule
